/* rtl/peqc_pkg.sv */
`default_nettype none
package peqc_pkg;
    localparam int CRIT_DEPTH = 12;
    localparam int RT_DEPTH   = 12;
    localparam int BG_DEPTH   = 6;
    localparam int STATE_KEYS = 7;
    localparam int HW         = 16;
    localparam int QAW        = 4;
    localparam int QCW        = 5;
    localparam int KEYW       = 3;
    localparam int MASKW      = 7;
    localparam logic [6:0] MASK_RESET = 7'd96;

    typedef enum logic [1:0] {FN_PUSH = 2'd0, FN_DEQ = 2'd1, FN_CLEAR = 2'd2, FN_FLUSH = 2'd3}
        func_t;
    typedef enum logic [1:0] {LV_CRIT = 2'd0, LV_RT = 2'd1, LV_STATE = 2'd2, LV_BG = 2'd3}
        lvl_t;
    typedef enum logic [1:0] {ST_OK = 2'd0, ST_INVALID = 2'd1, ST_FULL = 2'd2, ST_EMPTY = 2'd3}
        stat_t;
    typedef enum logic [1:0] {K_STATUS = 2'd0, K_EVENT = 2'd1, K_RELEASE = 2'd2} kind_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [HW-1:0]     handle;
        logic              type_is_none;
        logic [1:0]        level;
        logic [KEYW-1:0]   slot_key;
        logic signed [63:0] time_us;
    } item_in_t;

    typedef struct packed {
        logic [1:0]    kind;
        logic [HW-1:0] out_handle;
        logic [1:0]    out_level;
        logic [1:0]    status;
        logic          wake;
        logic          last;
        logic [5:0]    total_depth;
        logic [31:0]   drop_total;
        logic [31:0]   coalesce_total;
        logic [31:0]   channel_coalesce_total;
    } item_out_t;

    // commands from controller to datapath
    typedef struct packed {
        logic       load;      // capture input item
        logic       exec;      // apply push/deq/clear, emit its results
        logic       fl_emit;   // emit one flush release from selected source
        logic [1:0] fl_src;    // 0 crit 1 rt 2 bg 3 slot
        logic       fl_fin;    // zero counters, emit final ok
    } cmd_t;

    typedef struct packed {
        logic       crit_ne;
        logic       rt_ne;
        logic       bg_ne;
        logic       slot_ne;
        logic [1:0] func;
        logic       two_res;   // exec produces a release before the status
    } stat_bus_t;
endpackage
`default_nettype wire

/* rtl/peqc_ctrl.sv */
`default_nettype none
module peqc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire peqc_pkg::stat_bus_t sts,
    output peqc_pkg::cmd_t           cmd
);
    import peqc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_STAT  = 5'b00100,
        S_FLUSH = 5'b01000,
        S_FIN   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.func == FN_FLUSH)
                    state_next = S_FLUSH;
                else
                begin
                    cmd.exec = 1'b1;
                    state_next = sts.two_res ? S_STAT : S_IDLE;
                end
            end
            S_STAT:
                state_next = S_IDLE;
            S_FLUSH:
            begin
                priority if (sts.crit_ne)
                begin
                    cmd.fl_emit = 1'b1;
                    cmd.fl_src = 2'd0;
                end
                else if (sts.rt_ne)
                begin
                    cmd.fl_emit = 1'b1;
                    cmd.fl_src = 2'd1;
                end
                else if (sts.bg_ne)
                begin
                    cmd.fl_emit = 1'b1;
                    cmd.fl_src = 2'd2;
                end
                else if (sts.slot_ne)
                begin
                    cmd.fl_emit = 1'b1;
                    cmd.fl_src = 2'd3;
                end
                else
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.fl_fin = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE) else $error("load outside idle");
    a_fin_after_flush: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN |-> $past(state_reg) == S_FLUSH) else $error("bad fin");
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("start not taken");
endmodule
`default_nettype wire

/* rtl/peqc_dp.sv */
`default_nettype none
module peqc_dp (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire peqc_pkg::item_in_t        cmd_in,
    input  wire logic [peqc_pkg::MASKW-1:0] mask,
    input  wire peqc_pkg::cmd_t            cmd,
    output peqc_pkg::stat_bus_t            sts,
    output logic                           done,
    output peqc_pkg::item_out_t            result
);
    import peqc_pkg::*;

    item_in_t             in_reg;
    logic [HW-1:0]        crit_mem [CRIT_DEPTH];
    logic [HW-1:0]        rt_mem   [RT_DEPTH];
    logic [HW-1:0]        bg_mem   [BG_DEPTH];
    logic [QCW-1:0]       crit_cnt_reg, rt_cnt_reg;
    logic [2:0]           bg_cnt_reg;
    logic [QAW-1:0]       crit_rd_reg, rt_rd_reg;
    logic [2:0]           bg_rd_reg;
    logic [HW-1:0]        slot_h_reg [STATE_KEYS];
    logic signed [63:0]   slot_t_reg [STATE_KEYS];
    logic [31:0]          drop_reg, coal_reg, ccoal_reg;
    logic                 done_reg;
    item_out_t            res_reg;
    logic [5:0]           depth_next;
    // pending status after a release
    logic                 pend_reg;

    logic                 invalid, st_key_bad, is_chan;
    logic [MASKW:0]       mask_ext;
    logic [STATE_KEYS-1:0] occ;
    logic [KEYW-1:0]      low_key;
    logic                 any_slot;
    logic [QAW-1:0]       crit_wr, rt_wr;
    logic [2:0]           bg_wr;

    function automatic logic [QAW-1:0] inc_q(input logic [QAW-1:0] p, input int d);
        return (p == QAW'(d - 1)) ? '0 : p + 1'b1;
    endfunction
    function automatic logic [2:0] inc_b(input logic [2:0] p);
        return (p == 3'(BG_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        for (int k = 0; k < STATE_KEYS; k++)
            occ[k] = (k != 0) && (slot_h_reg[k] != '0);
        any_slot = |occ;
        low_key = '0;
        for (int k = STATE_KEYS - 1; k >= 1; k--)
            if (occ[k])
                low_key = KEYW'(k);
    end

    always_comb
    begin
        logic [QCW:0] w;
        w = (QCW+1)'(crit_rd_reg) + (QCW+1)'(crit_cnt_reg);
        crit_wr = (w >= (QCW+1)'(CRIT_DEPTH)) ? QAW'(w - (QCW+1)'(CRIT_DEPTH)) : QAW'(w);
        w = (QCW+1)'(rt_rd_reg) + (QCW+1)'(rt_cnt_reg);
        rt_wr = (w >= (QCW+1)'(RT_DEPTH)) ? QAW'(w - (QCW+1)'(RT_DEPTH)) : QAW'(w);
        w = (QCW+1)'(bg_rd_reg) + (QCW+1)'(bg_cnt_reg);
        bg_wr = (w >= (QCW+1)'(BG_DEPTH)) ? 3'(w - (QCW+1)'(BG_DEPTH)) : 3'(w);
    end

    // key 7 has no mask bit and is never a channel-state key
    assign mask_ext = {1'b0, mask};
    assign st_key_bad = (in_reg.slot_key == '0) ||
                        (32'(in_reg.slot_key) >= 32'(STATE_KEYS));
    assign is_chan = mask_ext[in_reg.slot_key];
    assign invalid = (in_reg.handle == '0) || in_reg.type_is_none ||
                     ((in_reg.level == LV_STATE) && st_key_bad);

    always_comb
    begin
        sts.crit_ne = crit_cnt_reg != '0;
        sts.rt_ne   = rt_cnt_reg != '0;
        sts.bg_ne   = bg_cnt_reg != '0;
        sts.slot_ne = any_slot;
        sts.func    = in_reg.func;
        sts.two_res = 1'b0;
        unique case (in_reg.func)
            FN_PUSH:
                sts.two_res = !invalid &&
                    (((in_reg.level == LV_STATE) && (slot_h_reg[in_reg.slot_key] != '0)) ||
                     ((in_reg.level == LV_BG) && (32'(bg_cnt_reg) >= 32'(BG_DEPTH))));
            FN_CLEAR:
                sts.two_res = !st_key_bad && is_chan && (slot_h_reg[in_reg.slot_key] != '0) &&
                    ((slot_t_reg[in_reg.slot_key] <= 64'sd0) ||
                     (slot_t_reg[in_reg.slot_key] <= in_reg.time_us));
            default:
                sts.two_res = 1'b0;
        endcase
    end

    always_comb
    begin
        logic [5:0] s;
        s = 6'(crit_cnt_reg) + 6'(rt_cnt_reg) + 6'(bg_cnt_reg);
        for (int k = 1; k < STATE_KEYS; k++)
            s = s + 6'(occ[k]);
        depth_next = s;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            in_reg <= cmd_in;
        if (cmd.exec && in_reg.func == FN_PUSH && !invalid)
        begin
            if (in_reg.level == LV_CRIT && 32'(crit_cnt_reg) < 32'(CRIT_DEPTH))
                crit_mem[crit_wr] <= in_reg.handle;
            if (in_reg.level == LV_RT && 32'(rt_cnt_reg) < 32'(RT_DEPTH))
                rt_mem[rt_wr] <= in_reg.handle;
            if (in_reg.level == LV_BG && 32'(bg_cnt_reg) < 32'(BG_DEPTH))
                bg_mem[bg_wr] <= in_reg.handle;
            if (in_reg.level == LV_STATE)
                slot_t_reg[in_reg.slot_key] <= in_reg.time_us;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        item_out_t res_next;
        if (!rst_n)
        begin
            crit_cnt_reg <= '0; rt_cnt_reg <= '0; bg_cnt_reg <= '0;
            crit_rd_reg <= '0; rt_rd_reg <= '0; bg_rd_reg <= '0;
            for (int k = 0; k < STATE_KEYS; k++)
                slot_h_reg[k] <= '0;
            drop_reg <= '0; coal_reg <= '0; ccoal_reg <= '0;
            done_reg <= 1'b0;
            pend_reg <= 1'b0;
            res_reg <= '0;
        end
        else
        begin
            res_next = res_reg;
            done_reg <= pend_reg || cmd.exec || cmd.fl_emit || cmd.fl_fin;
            pend_reg <= cmd.exec && sts.two_res;
            if (pend_reg)
            begin
                // status after a release
                res_next = '0;
                res_next.status = ST_OK;
                res_next.last = 1'b1;
            end
            if (cmd.exec)
            begin
                res_next = '0;
                res_next.last = !sts.two_res;
                unique case (in_reg.func)
                    FN_PUSH:
                    begin
                        if (invalid)
                            res_next.status = ST_INVALID;
                        else
                        begin
                            unique case (in_reg.level)
                                LV_CRIT:
                                    if (32'(crit_cnt_reg) < 32'(CRIT_DEPTH))
                                    begin
                                        crit_cnt_reg <= crit_cnt_reg + 1'b1;
                                        res_next.wake = 1'b1;
                                    end
                                    else
                                        res_next.status = ST_FULL;
                                LV_RT:
                                    if (32'(rt_cnt_reg) < 32'(RT_DEPTH))
                                    begin
                                        rt_cnt_reg <= rt_cnt_reg + 1'b1;
                                        res_next.wake = 1'b1;
                                    end
                                    else
                                        res_next.status = ST_FULL;
                                LV_STATE:
                                begin
                                    slot_h_reg[in_reg.slot_key] <= in_reg.handle;
                                    if (slot_h_reg[in_reg.slot_key] != '0)
                                    begin
                                        res_next.kind = K_RELEASE;
                                        res_next.out_handle = slot_h_reg[in_reg.slot_key];
                                        res_next.out_level = LV_STATE;
                                        coal_reg <= coal_reg + 1'b1;
                                        if (is_chan)
                                            ccoal_reg <= ccoal_reg + 1'b1;
                                    end
                                    else
                                        res_next.wake = 1'b1;
                                end
                                LV_BG:
                                    if (32'(bg_cnt_reg) < 32'(BG_DEPTH))
                                        bg_cnt_reg <= bg_cnt_reg + 1'b1;
                                    else
                                    begin
                                        drop_reg <= drop_reg + 1'b1;
                                        res_next.kind = K_RELEASE;
                                        res_next.out_handle = in_reg.handle;
                                        res_next.out_level = LV_BG;
                                    end
                                default: ;
                            endcase
                        end
                    end
                    FN_DEQ:
                    begin
                        res_next.kind = K_EVENT;
                        priority if (crit_cnt_reg != '0)
                        begin
                            res_next.out_handle = crit_mem[crit_rd_reg];
                            res_next.out_level = LV_CRIT;
                            crit_rd_reg <= inc_q(crit_rd_reg, CRIT_DEPTH);
                            crit_cnt_reg <= crit_cnt_reg - 1'b1;
                        end
                        else if (rt_cnt_reg != '0)
                        begin
                            res_next.out_handle = rt_mem[rt_rd_reg];
                            res_next.out_level = LV_RT;
                            rt_rd_reg <= inc_q(rt_rd_reg, RT_DEPTH);
                            rt_cnt_reg <= rt_cnt_reg - 1'b1;
                        end
                        else if (any_slot)
                        begin
                            res_next.out_handle = slot_h_reg[low_key];
                            res_next.out_level = LV_STATE;
                            slot_h_reg[low_key] <= '0;
                        end
                        else if (bg_cnt_reg != '0)
                        begin
                            res_next.out_handle = bg_mem[bg_rd_reg];
                            res_next.out_level = LV_BG;
                            bg_rd_reg <= inc_b(bg_rd_reg);
                            bg_cnt_reg <= bg_cnt_reg - 1'b1;
                        end
                        else
                        begin
                            res_next.kind = K_STATUS;
                            res_next.status = ST_EMPTY;
                        end
                    end
                    FN_CLEAR:
                    begin
                        if (st_key_bad || !is_chan)
                            res_next.status = ST_INVALID;
                        else if (sts.two_res)
                        begin
                            res_next.kind = K_RELEASE;
                            res_next.out_handle = slot_h_reg[in_reg.slot_key];
                            res_next.out_level = LV_STATE;
                            slot_h_reg[in_reg.slot_key] <= '0;
                        end
                    end
                    default: ;
                endcase
            end
            if (cmd.fl_emit)
            begin
                res_next = '0;
                res_next.kind = K_RELEASE;
                unique case (cmd.fl_src)
                    2'd0:
                    begin
                        res_next.out_handle = crit_mem[crit_rd_reg];
                        res_next.out_level = LV_CRIT;
                        crit_rd_reg <= inc_q(crit_rd_reg, CRIT_DEPTH);
                        crit_cnt_reg <= crit_cnt_reg - 1'b1;
                    end
                    2'd1:
                    begin
                        res_next.out_handle = rt_mem[rt_rd_reg];
                        res_next.out_level = LV_RT;
                        rt_rd_reg <= inc_q(rt_rd_reg, RT_DEPTH);
                        rt_cnt_reg <= rt_cnt_reg - 1'b1;
                    end
                    2'd2:
                    begin
                        res_next.out_handle = bg_mem[bg_rd_reg];
                        res_next.out_level = LV_BG;
                        bg_rd_reg <= inc_b(bg_rd_reg);
                        bg_cnt_reg <= bg_cnt_reg - 1'b1;
                    end
                    default:
                    begin
                        res_next.out_handle = slot_h_reg[low_key];
                        res_next.out_level = LV_STATE;
                        slot_h_reg[low_key] <= '0;
                    end
                endcase
            end
            if (cmd.fl_fin)
            begin
                res_next = '0;
                res_next.last = 1'b1;
                drop_reg <= '0; coal_reg <= '0; ccoal_reg <= '0;
            end
            res_reg <= res_next;
        end
    end

    // flush releases all carry zero counters and the final depth of zero
    logic in_flush;
    assign in_flush = in_reg.func == FN_FLUSH;
    assign done = done_reg;

    always_comb
    begin
        result = res_reg;
        if (in_flush)
        begin
            result.total_depth = '0;
            result.drop_total = '0;
            result.coalesce_total = '0;
            result.channel_coalesce_total = '0;
        end
        else
        begin
            result.total_depth = depth_next;
            result.drop_total = drop_reg;
            result.coalesce_total = coal_reg;
            result.channel_coalesce_total = ccoal_reg;
        end
    end

    a_cnt_crit: assert property (@(posedge clk) disable iff (!rst_n)
        32'(crit_cnt_reg) <= 32'(CRIT_DEPTH)) else $error("crit overflow");
    a_cnt_bg: assert property (@(posedge clk) disable iff (!rst_n)
        32'(bg_cnt_reg) <= 32'(BG_DEPTH)) else $error("bg overflow");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.exec, cmd.fl_emit, cmd.fl_fin, cmd.load}) <= 1) else $error("cmd clash");
endmodule
`default_nettype wire

/* rtl/priority_event_queue_coalescing.sv */
`default_nettype none
// channel   | ports                              | handshake
// command   | start, busy, cmd_in                | taken when start && !busy
// result    | done, result                       | each result valid for one cycle, no stall
// config    | cfg_we, cfg_data                   | written when cfg_we
// Push, dequeue and clear pass through the EXEC state, and through STAT as well
// when a release precedes the status. Flush passes through EXEC, then FLUSH
// releases the held handles one per cycle, and FIN ends it.
// Reset empties all queues and slots and zeroes the counters.
// The receiver cannot stall; results appear on done for one cycle each.
module priority_event_queue_coalescing (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire peqc_pkg::item_in_t         cmd_in,
    output logic                            done,
    output peqc_pkg::item_out_t             result,
    input  wire logic                       cfg_we,
    input  wire logic [peqc_pkg::MASKW-1:0] cfg_data
);
    import peqc_pkg::*;

    logic [MASKW-1:0] mask_reg;
    cmd_t             cmd;
    stat_bus_t        sts;
    logic             busy_c, done_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= MASK_RESET;
        else if (cfg_we)
            mask_reg <= cfg_data;
    end

    peqc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy_c),
        .sts   (sts),
        .cmd   (cmd)
    );

    peqc_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_in (cmd_in),
        .mask   (mask_reg),
        .cmd    (cmd),
        .sts    (sts),
        .done   (done_c),
        .result (result)
    );

    // hold busy until the last result has left
    logic tail_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tail_reg <= 1'b0;
        else
            tail_reg <= busy_c || (tail_reg && !(done_c && result.last));
    end
    assign busy = busy_c || (tail_reg && !(done_c && result.last));
    assign done = done_c;
endmodule
`default_nettype wire

/* verif/priority_event_queue_coalescing_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module priority_event_queue_coalescing_tb;
    import peqc_pkg::*;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    item_in_t cmd_in;
    logic done;
    item_out_t result;
    logic cfg_we;
    logic [MASKW-1:0] cfg_data;

    priority_event_queue_coalescing dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd_in(cmd_in),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // queue model state
    logic [HW-1:0] crit_q[$];
    logic [HW-1:0] rt_q[$];
    logic [HW-1:0] bg_q[$];
    logic [HW-1:0] slot_h[STATE_KEYS];
    logic signed [63:0] slot_t[STATE_KEYS];
    logic [31:0] drops, coalesces, chan_coalesces;
    logic [MASKW-1:0] chan_mask;

    item_out_t expected_results[$];
    int errors = 0;
    int idle_pct = 20;
    int idle_cycles = 0;

    function automatic item_out_t mk(kind_t k, logic [HW-1:0] h, lvl_t l, stat_t s);
        item_out_t r;
        r = '0;
        r.kind = k;
        r.out_handle = h;
        r.out_level = l;
        r.status = s;
        return r;
    endfunction

    function automatic logic [5:0] held_count();
        int d;
        d = crit_q.size() + rt_q.size() + bg_q.size();
        for (int i = 1; i < STATE_KEYS; i++)
            if (slot_h[i] != 0) d++;
        return d[5:0];
    endfunction

    // compute the results of one command and advance the queue model
    task automatic predict_queue(item_in_t c);
        item_out_t r[$];
        logic wake;
        stat_t st;
        int key;
        logic found;
        wake = 1'b0;
        st = ST_OK;
        key = c.slot_key;
        found = 1'b0;
        case (func_t'(c.func))
            FN_PUSH:
            begin
                if (c.handle == 0 || c.type_is_none ||
                    (c.level == LV_STATE && (key == 0 || key >= STATE_KEYS)))
                    st = ST_INVALID;
                else if (c.level == LV_CRIT)
                begin
                    if (crit_q.size() < CRIT_DEPTH)
                    begin
                        crit_q.push_back(c.handle);
                        wake = 1'b1;
                    end
                    else st = ST_FULL;
                end
                else if (c.level == LV_RT)
                begin
                    if (rt_q.size() < RT_DEPTH)
                    begin
                        rt_q.push_back(c.handle);
                        wake = 1'b1;
                    end
                    else st = ST_FULL;
                end
                else if (c.level == LV_STATE)
                begin
                    if (slot_h[key] != 0)
                    begin
                        r.push_back(mk(K_RELEASE, slot_h[key], LV_STATE, ST_OK));
                        coalesces++;
                        if (chan_mask[key]) chan_coalesces++;
                    end
                    else wake = 1'b1;
                    slot_h[key] = c.handle;
                    slot_t[key] = c.time_us;
                end
                else if (bg_q.size() < BG_DEPTH)
                    bg_q.push_back(c.handle);
                else
                begin
                    drops++;
                    r.push_back(mk(K_RELEASE, c.handle, LV_BG, ST_OK));
                end
                r.push_back(mk(K_STATUS, '0, LV_CRIT, st));
            end
            FN_DEQ:
            begin
                if (crit_q.size() > 0)
                    r.push_back(mk(K_EVENT, crit_q.pop_front(), LV_CRIT, ST_OK));
                else if (rt_q.size() > 0)
                    r.push_back(mk(K_EVENT, rt_q.pop_front(), LV_RT, ST_OK));
                else
                begin
                    for (int i = 1; i < STATE_KEYS; i++)
                        if (!found && slot_h[i] != 0)
                        begin
                            r.push_back(mk(K_EVENT, slot_h[i], LV_STATE, ST_OK));
                            slot_h[i] = 0;
                            slot_t[i] = 0;
                            found = 1'b1;
                        end
                    if (!found)
                    begin
                        if (bg_q.size() > 0)
                            r.push_back(mk(K_EVENT, bg_q.pop_front(), LV_BG, ST_OK));
                        else
                            r.push_back(mk(K_STATUS, '0, LV_CRIT, ST_EMPTY));
                    end
                end
            end
            FN_CLEAR:
            begin
                if (key == 0 || key >= STATE_KEYS || !chan_mask[key])
                    st = ST_INVALID;
                else if (slot_h[key] != 0 && (slot_t[key] <= 0 || slot_t[key] <= c.time_us))
                begin
                    r.push_back(mk(K_RELEASE, slot_h[key], LV_STATE, ST_OK));
                    slot_h[key] = 0;
                    slot_t[key] = 0;
                end
                r.push_back(mk(K_STATUS, '0, LV_CRIT, st));
            end
            default:
            begin
                foreach (crit_q[i]) r.push_back(mk(K_RELEASE, crit_q[i], LV_CRIT, ST_OK));
                foreach (rt_q[i]) r.push_back(mk(K_RELEASE, rt_q[i], LV_RT, ST_OK));
                foreach (bg_q[i]) r.push_back(mk(K_RELEASE, bg_q[i], LV_BG, ST_OK));
                for (int i = 0; i < STATE_KEYS; i++)
                begin
                    if (slot_h[i] != 0) r.push_back(mk(K_RELEASE, slot_h[i], LV_STATE, ST_OK));
                    slot_h[i] = 0;
                    slot_t[i] = 0;
                end
                crit_q.delete();
                rt_q.delete();
                bg_q.delete();
                drops = 0;
                coalesces = 0;
                chan_coalesces = 0;
                r.push_back(mk(K_STATUS, '0, LV_CRIT, ST_OK));
            end
        endcase
        foreach (r[i])
        begin
            r[i].last = (i == r.size() - 1);
            r[i].wake = (i == r.size() - 1) ? wake : 1'b0;
            r[i].total_depth = held_count();
            r[i].drop_total = drops;
            r[i].coalesce_total = coalesces;
            r[i].channel_coalesce_total = chan_coalesces;
            expected_results.push_back(r[i]);
        end
    endtask

    task automatic send_cmd(item_in_t c);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
            @(posedge clk);
        start <= 1'b1;
        cmd_in <= c;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_queue(c);
        // busy is high for the cycle after acceptance, so no slot is lost
        start <= 1'b0;
        @(posedge clk);
    endtask

    function automatic item_in_t cmd(func_t f, logic [HW-1:0] h, lvl_t l, int key,
                                     logic signed [63:0] t);
        item_in_t c;
        c.func = f;
        c.handle = h;
        c.type_is_none = 1'b0;
        c.level = l;
        c.slot_key = key[2:0];
        c.time_us = t;
        return c;
    endfunction

    task automatic wait_drain();
        while (expected_results.size() > 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_mask(logic [MASKW-1:0] m);
        cfg_we <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        chan_mask = m;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            idle_cycles <= 0;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result %p", result);
                errors++;
            end
            else
            begin
                item_out_t e;
                e = expected_results.pop_front();
                if (result.kind !== e.kind)
                begin $error("kind exp %0d got %0d", e.kind, result.kind); errors++; end
                if (result.out_handle !== e.out_handle)
                begin
                    $error("out_handle exp %h got %h", e.out_handle, result.out_handle);
                    errors++;
                end
                if (result.out_level !== e.out_level)
                begin
                    $error("out_level exp %0d got %0d", e.out_level, result.out_level);
                    errors++;
                end
                if (result.status !== e.status)
                begin $error("status exp %0d got %0d", e.status, result.status); errors++; end
                if (result.wake !== e.wake)
                begin $error("wake exp %0d got %0d", e.wake, result.wake); errors++; end
                if (result.last !== e.last)
                begin $error("last exp %0d got %0d", e.last, result.last); errors++; end
                if (result.total_depth !== e.total_depth)
                begin
                    $error("total_depth exp %0d got %0d", e.total_depth, result.total_depth);
                    errors++;
                end
                if (result.drop_total !== e.drop_total)
                begin
                    $error("drop_total exp %0d got %0d", e.drop_total, result.drop_total);
                    errors++;
                end
                if (result.coalesce_total !== e.coalesce_total)
                begin
                    $error("coalesce_total exp %0d got %0d", e.coalesce_total,
                           result.coalesce_total);
                    errors++;
                end
                if (result.channel_coalesce_total !== e.channel_coalesce_total)
                begin
                    $error("channel_coalesce_total exp %0d got %0d",
                           e.channel_coalesce_total, result.channel_coalesce_total);
                    errors++;
                end
            end
        end
        else if (start && !busy)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (idle_cycles > 2000)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic signed [63:0] rand_time();
        logic signed [63:0] t;
        t = {$urandom, $urandom};
        case ($urandom_range(3))
            0: t = 64'sh8000_0000_0000_0000;
            1: t = 64'sh7FFF_FFFF_FFFF_FFFF;
            2: t = $signed({{48{1'b0}}, 16'($urandom)}) - 64'sd1000;
            default: ;
        endcase
        return t;
    endfunction

    task automatic test_directed();
        item_in_t c;
        c = cmd(FN_DEQ, 0, LV_CRIT, 0, 0);
        send_cmd(c);                                        // empty dequeue
        send_cmd(cmd(FN_PUSH, 0, LV_CRIT, 0, 0));            // handle zero
        c = cmd(FN_PUSH, 16'hFFFF, LV_RT, 0, 0);
        c.type_is_none = 1'b1;
        send_cmd(c);                                        // type none
        send_cmd(cmd(FN_PUSH, 16'h0011, LV_STATE, 0, 5));    // key zero
        send_cmd(cmd(FN_PUSH, 16'h0012, LV_STATE, 7, 5));    // key out of range
        send_cmd(cmd(FN_PUSH, 16'hFFFF, LV_CRIT, 0, 0));
        send_cmd(cmd(FN_PUSH, 16'h0001, LV_RT, 0, 0));
        send_cmd(cmd(FN_PUSH, 16'h0101, LV_STATE, 5, 64'sh7FFF_FFFF_FFFF_FFFF));
        send_cmd(cmd(FN_PUSH, 16'h0102, LV_STATE, 5, 64'sh7FFF_FFFF_FFFF_FFFF));
        send_cmd(cmd(FN_PUSH, 16'h0103, LV_STATE, 1, 0));
        send_cmd(cmd(FN_PUSH, 16'h0104, LV_STATE, 1, 1));    // coalesce non-channel key
        send_cmd(cmd(FN_PUSH, 16'h0201, LV_BG, 0, 0));
        send_cmd(cmd(FN_CLEAR, 0, LV_CRIT, 0, 0));          // clear key zero
        send_cmd(cmd(FN_CLEAR, 0, LV_CRIT, 1, 0));          // key not channel
        send_cmd(cmd(FN_CLEAR, 0, LV_CRIT, 5, 64'sh8000_0000_0000_0000)); // keep
        send_cmd(cmd(FN_CLEAR, 0, LV_CRIT, 5, 64'sh7FFF_FFFF_FFFF_FFFF)); // release
        send_cmd(cmd(FN_PUSH, 16'h0105, LV_STATE, 6, -64'sd5));
        send_cmd(cmd(FN_CLEAR, 0, LV_CRIT, 6, 64'sh8000_0000_0000_0000)); // time <= 0
        for (int i = 0; i < 5; i++)
            send_cmd(cmd(FN_DEQ, 0, LV_CRIT, 0, 0));
        send_cmd(cmd(FN_FLUSH, 0, LV_CRIT, 0, 0));
    endtask

    task automatic test_fill_levels();
        // overfill the FIFOs so full and drop paths show up, then flush
        for (int i = 0; i < 13; i++) send_cmd(cmd(FN_PUSH, 16'(i + 1), LV_CRIT, 0, 0));
        for (int i = 0; i < 13; i++) send_cmd(cmd(FN_PUSH, 16'(i + 40), LV_RT, 0, 0));
        for (int i = 0; i < 8; i++) send_cmd(cmd(FN_PUSH, 16'(i + 80), LV_BG, 0, 0));
        for (int k = 1; k < STATE_KEYS; k++)
            send_cmd(cmd(FN_PUSH, 16'(k + 120), LV_STATE, k, 0));
        send_cmd(cmd(FN_FLUSH, 0, LV_CRIT, 0, 0));
    endtask

    task automatic test_random(int n);
        item_in_t c;
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 3) idle_pct = 0;           // burst with no gaps
            if (i == n / 2) idle_pct = 20;
            c.func = ($urandom_range(99) < 55) ? FN_PUSH :
                     ($urandom_range(99) < 60) ? FN_DEQ :
                     ($urandom_range(99) < 85) ? FN_CLEAR : FN_FLUSH;
            c.handle = ($urandom_range(99) < 3) ? 16'h0 : 16'($urandom);
            c.type_is_none = ($urandom_range(99) < 4);
            c.level = 2'($urandom_range(3));
            c.slot_key = ($urandom_range(99) < 90) ? 3'($urandom_range(1, 6)) :
                                                    3'($urandom_range(7));
            c.time_us = rand_time();
            send_cmd(c);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd_in = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        chan_mask = MASK_RESET;
        drops = 0;
        coalesces = 0;
        chan_coalesces = 0;
        for (int i = 0; i < STATE_KEYS; i++)
        begin
            slot_h[i] = 0;
            slot_t[i] = 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fill_levels();
        wait_drain();
        write_mask(7'h7F);
        test_random(60);
        wait_drain();
        write_mask(7'h00);
        test_random(40);
        wait_drain();
        write_mask(7'h2A);
        test_random(55);
        wait_drain();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
rtl/peqc_pkg.sv
rtl/peqc_ctrl.sv
rtl/peqc_dp.sv
rtl/priority_event_queue_coalescing.sv
verif/priority_event_queue_coalescing_tb.sv
